@@ rtl/point_to_segment_distance_macros.svh @@
// Assertion macros for the point-to-segment distance block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef POINT_TO_SEGMENT_DISTANCE_MACROS_SVH
`define POINT_TO_SEGMENT_DISTANCE_MACROS_SVH

// The antecedent implies the consequent at the same clock edge.
`define PTSD_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point_to_segment_distance: implication check failed");

// The condition never holds outside reset.
`define PTSD_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("point_to_segment_distance: forbidden condition seen");

`endif

@@ rtl/ptsd_pkg.sv @@
// Shared widths and stage payload types for the point-to-segment distance block.
// No dependencies.
`default_nettype none

package ptsd_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int IN_W        = 32;
    localparam int OUT_W       = 32;
    localparam int DIST_W      = 33;
    localparam int DW          = COORD_WIDTH + 1;
    localparam int PW          = 2 * DW;
    localparam int SW          = PW + 1;
    localparam int SPLIT       = (SW + 1) / 2;
    localparam int HW          = SW - SPLIT;
    localparam int QW          = DW;
    localparam int NW          = SW + QW;
    localparam int RW          = (SW + 1) / 2;
    localparam int XW          = 2 * RW;
    localparam int LATENCY     = 11 + QW + RW;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] base_x;
        logic signed [COORD_WIDTH-1:0] base_y;
        logic signed [COORD_WIDTH-1:0] qry_x;
        logic signed [COORD_WIDTH-1:0] qry_y;
        logic                          neg_x;
        logic                          neg_y;
        logic                          interior;
    } side_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] px;
        logic signed [OUT_W-1:0] py;
        logic                    at_endpoint;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/ptsd_front.sv @@
// Front stages: differences, products, dot and length sums, endpoint choice and
// the partial products of the projection numerators. Depends on ptsd_pkg.
`default_nettype none

module ptsd_front (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          valid_in,
    input  wire  [ptsd_pkg::IN_W-1:0]    seg_a_x,
    input  wire  [ptsd_pkg::IN_W-1:0]    seg_a_y,
    input  wire  [ptsd_pkg::IN_W-1:0]    seg_b_x,
    input  wire  [ptsd_pkg::IN_W-1:0]    seg_b_y,
    input  wire  [ptsd_pkg::IN_W-1:0]    query_x,
    input  wire  [ptsd_pkg::IN_W-1:0]    query_y,
    output logic                         valid_out,
    output logic [ptsd_pkg::NW-1:0]      num_x,
    output logic [ptsd_pkg::NW-1:0]      num_y,
    output logic [ptsd_pkg::SW-1:0]      dd,
    output ptsd_pkg::side_t              side
);
    import ptsd_pkg::*;

    logic signed [COORD_WIDTH-1:0] ax, ay, bx, by, qx, qy;

    logic                          v1_reg;
    logic signed [DW-1:0]          dx1_reg, dy1_reg, wx1_reg, wy1_reg, vx1_reg, vy1_reg;
    logic signed [COORD_WIDTH-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg, qx1_reg, qy1_reg;

    logic                          v2_reg;
    logic signed [PW-1:0]          pdx2_reg, pdy2_reg, sdx2_reg, sdy2_reg;
    logic signed [PW-1:0]          swx2_reg, swy2_reg, svx2_reg, svy2_reg;
    logic [DW-1:0]                 mx2_reg, my2_reg;
    logic                          nx2_reg, ny2_reg;
    logic signed [COORD_WIDTH-1:0] ax2_reg, ay2_reg, bx2_reg, by2_reg, qx2_reg, qy2_reg;

    logic                          v3_reg;
    logic signed [SW-1:0]          dot3_reg;
    logic [SW-1:0]                 dd3_reg, da3_reg, db3_reg;
    logic [DW-1:0]                 mx3_reg, my3_reg;
    logic                          nx3_reg, ny3_reg;
    logic signed [COORD_WIDTH-1:0] ax3_reg, ay3_reg, bx3_reg, by3_reg, qx3_reg, qy3_reg;

    logic                          v4_reg;
    logic [SPLIT+DW-1:0]           plx4_reg, ply4_reg;
    logic [HW+DW-1:0]              phx4_reg, phy4_reg;
    logic [SW-1:0]                 dd4_reg;
    side_t                         side4_reg;

    logic                          interior_next, near_a_next;
    side_t                         side4_next;
    logic [SPLIT-1:0]              dot_lo;
    logic [HW-1:0]                 dot_hi;

    logic                          v5_reg;
    logic [NW-1:0]                 nx5_reg, ny5_reg;
    logic [SW-1:0]                 dd5_reg;
    side_t                         side5_reg;

    assign ax = seg_a_x[COORD_WIDTH-1:0];
    assign ay = seg_a_y[COORD_WIDTH-1:0];
    assign bx = seg_b_x[COORD_WIDTH-1:0];
    assign by = seg_b_y[COORD_WIDTH-1:0];
    assign qx = query_x[COORD_WIDTH-1:0];
    assign qy = query_y[COORD_WIDTH-1:0];

    always_comb
    begin
        interior_next = !dot3_reg[SW-1] && (dot3_reg != '0) && ($unsigned(dot3_reg) < dd3_reg);
        near_a_next   = da3_reg < db3_reg;
        side4_next.qry_x    = qx3_reg;
        side4_next.qry_y    = qy3_reg;
        side4_next.neg_x    = nx3_reg;
        side4_next.neg_y    = ny3_reg;
        side4_next.interior = interior_next;
        if (interior_next || near_a_next)
        begin
            side4_next.base_x = ax3_reg;
            side4_next.base_y = ay3_reg;
        end
        else
        begin
            side4_next.base_x = bx3_reg;
            side4_next.base_y = by3_reg;
        end
        dot_lo = dot3_reg[SPLIT-1:0];
        dot_hi = dot3_reg[SW-1:SPLIT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx1_reg <= DW'(bx) - DW'(ax);
        dy1_reg <= DW'(by) - DW'(ay);
        wx1_reg <= DW'(qx) - DW'(ax);
        wy1_reg <= DW'(qy) - DW'(ay);
        vx1_reg <= DW'(qx) - DW'(bx);
        vy1_reg <= DW'(qy) - DW'(by);
        ax1_reg <= ax;
        ay1_reg <= ay;
        bx1_reg <= bx;
        by1_reg <= by;
        qx1_reg <= qx;
        qy1_reg <= qy;

        pdx2_reg <= wx1_reg * dx1_reg;
        pdy2_reg <= wy1_reg * dy1_reg;
        sdx2_reg <= dx1_reg * dx1_reg;
        sdy2_reg <= dy1_reg * dy1_reg;
        swx2_reg <= wx1_reg * wx1_reg;
        swy2_reg <= wy1_reg * wy1_reg;
        svx2_reg <= vx1_reg * vx1_reg;
        svy2_reg <= vy1_reg * vy1_reg;
        mx2_reg  <= dx1_reg[DW-1] ? DW'(-dx1_reg) : DW'(dx1_reg);
        my2_reg  <= dy1_reg[DW-1] ? DW'(-dy1_reg) : DW'(dy1_reg);
        nx2_reg  <= dx1_reg[DW-1];
        ny2_reg  <= dy1_reg[DW-1];
        ax2_reg  <= ax1_reg;
        ay2_reg  <= ay1_reg;
        bx2_reg  <= bx1_reg;
        by2_reg  <= by1_reg;
        qx2_reg  <= qx1_reg;
        qy2_reg  <= qy1_reg;

        dot3_reg <= SW'(pdx2_reg) + SW'(pdy2_reg);
        dd3_reg  <= SW'($unsigned(sdx2_reg)) + SW'($unsigned(sdy2_reg));
        da3_reg  <= SW'($unsigned(swx2_reg)) + SW'($unsigned(swy2_reg));
        db3_reg  <= SW'($unsigned(svx2_reg)) + SW'($unsigned(svy2_reg));
        mx3_reg  <= mx2_reg;
        my3_reg  <= my2_reg;
        nx3_reg  <= nx2_reg;
        ny3_reg  <= ny2_reg;
        ax3_reg  <= ax2_reg;
        ay3_reg  <= ay2_reg;
        bx3_reg  <= bx2_reg;
        by3_reg  <= by2_reg;
        qx3_reg  <= qx2_reg;
        qy3_reg  <= qy2_reg;

        plx4_reg  <= dot_lo * mx3_reg;
        ply4_reg  <= dot_lo * my3_reg;
        phx4_reg  <= dot_hi * mx3_reg;
        phy4_reg  <= dot_hi * my3_reg;
        dd4_reg   <= dd3_reg;
        side4_reg <= side4_next;

        nx5_reg   <= NW'(plx4_reg) + (NW'(phx4_reg) << SPLIT);
        ny5_reg   <= NW'(ply4_reg) + (NW'(phy4_reg) << SPLIT);
        dd5_reg   <= dd4_reg;
        side5_reg <= side4_reg;
    end

    assign valid_out = v5_reg;
    assign num_x     = nx5_reg;
    assign num_y     = ny5_reg;
    assign dd        = dd5_reg;
    assign side      = side5_reg;

endmodule

`default_nettype wire

@@ rtl/ptsd_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing
// one divisor. Depends on ptsd_pkg.
`default_nettype none

module ptsd_div (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          valid_in,
    input  wire  [ptsd_pkg::NW-1:0]      num_x,
    input  wire  [ptsd_pkg::NW-1:0]      num_y,
    input  wire  [ptsd_pkg::SW-1:0]      dd,
    input  ptsd_pkg::side_t              side_in,
    output logic                         valid_out,
    output logic [ptsd_pkg::QW-1:0]      quot_x,
    output logic [ptsd_pkg::QW-1:0]      quot_y,
    output ptsd_pkg::side_t              side_out
);
    import ptsd_pkg::*;

    logic          v_reg    [0:QW];
    logic [SW-1:0] rx_reg   [0:QW];
    logic [SW-1:0] ry_reg   [0:QW];
    logic [QW-1:0] lx_reg   [0:QW];
    logic [QW-1:0] ly_reg   [0:QW];
    logic [QW-1:0] qx_reg   [0:QW];
    logic [QW-1:0] qy_reg   [0:QW];
    logic [SW-1:0] d_reg    [0:QW];
    side_t         side_reg [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_reg[0]   <= num_x[NW-1:QW];
        ry_reg[0]   <= num_y[NW-1:QW];
        lx_reg[0]   <= num_x[QW-1:0];
        ly_reg[0]   <= num_y[QW-1:0];
        qx_reg[0]   <= '0;
        qy_reg[0]   <= '0;
        d_reg[0]    <= dd;
        side_reg[0] <= side_in;
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [SW:0] cand_x, cand_y;
        logic        ge_x, ge_y;
        logic [SW:0] diff_x, diff_y;

        always_comb
        begin
            cand_x = {rx_reg[k], lx_reg[k][QW-1]};
            cand_y = {ry_reg[k], ly_reg[k][QW-1]};
            ge_x   = cand_x >= {1'b0, d_reg[k]};
            ge_y   = cand_y >= {1'b0, d_reg[k]};
            diff_x = ge_x ? cand_x - {1'b0, d_reg[k]} : cand_x;
            diff_y = ge_y ? cand_y - {1'b0, d_reg[k]} : cand_y;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rx_reg[k+1]   <= diff_x[SW-1:0];
            ry_reg[k+1]   <= diff_y[SW-1:0];
            lx_reg[k+1]   <= lx_reg[k] << 1;
            ly_reg[k+1]   <= ly_reg[k] << 1;
            qx_reg[k+1]   <= {qx_reg[k][QW-2:0], ge_x};
            qy_reg[k+1]   <= {qy_reg[k][QW-2:0], ge_y};
            d_reg[k+1]    <= d_reg[k];
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign valid_out = v_reg[QW];
    assign quot_x    = qx_reg[QW];
    assign quot_y    = qy_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

`default_nettype wire

@@ rtl/ptsd_back.sv @@
// Back stages: closest point from the quotients, offset to the query point and
// its squared length. Depends on ptsd_pkg.
`default_nettype none

module ptsd_back (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          valid_in,
    input  wire  [ptsd_pkg::QW-1:0]      quot_x,
    input  wire  [ptsd_pkg::QW-1:0]      quot_y,
    input  ptsd_pkg::side_t              side,
    output logic                         valid_out,
    output logic [ptsd_pkg::SW-1:0]      len2,
    output ptsd_pkg::res_t               res
);
    import ptsd_pkg::*;

    logic                          v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [COORD_WIDTH-1:0] px1_reg, py1_reg, qx1_reg, qy1_reg;
    logic                          end1_reg;
    logic signed [COORD_WIDTH-1:0] px_next, py_next;
    logic signed [DW-1:0]          ex2_reg, ey2_reg;
    logic signed [PW-1:0]          sx3_reg, sy3_reg;
    logic [SW-1:0]                 n4_reg;
    res_t                          r2_reg, r3_reg, r4_reg;

    always_comb
    begin
        px_next = side.base_x;
        py_next = side.base_y;
        if (side.interior)
        begin
            px_next = side.neg_x ? side.base_x - quot_x[COORD_WIDTH-1:0]
                                 : side.base_x + quot_x[COORD_WIDTH-1:0];
            py_next = side.neg_y ? side.base_y - quot_y[COORD_WIDTH-1:0]
                                 : side.base_y + quot_y[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        px1_reg  <= px_next;
        py1_reg  <= py_next;
        qx1_reg  <= side.qry_x;
        qy1_reg  <= side.qry_y;
        end1_reg <= !side.interior;

        ex2_reg            <= DW'(qx1_reg) - DW'(px1_reg);
        ey2_reg            <= DW'(qy1_reg) - DW'(py1_reg);
        r2_reg.px          <= OUT_W'(px1_reg);
        r2_reg.py          <= OUT_W'(py1_reg);
        r2_reg.at_endpoint <= end1_reg;

        sx3_reg <= ex2_reg * ex2_reg;
        sy3_reg <= ey2_reg * ey2_reg;
        r3_reg  <= r2_reg;

        n4_reg  <= SW'($unsigned(sx3_reg)) + SW'($unsigned(sy3_reg));
        r4_reg  <= r3_reg;
    end

    assign valid_out = v4_reg;
    assign len2      = n4_reg;
    assign res       = r4_reg;

endmodule

`default_nettype wire

@@ rtl/ptsd_sqrt.sv @@
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on ptsd_pkg.
`default_nettype none

module ptsd_sqrt (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          valid_in,
    input  wire  [ptsd_pkg::SW-1:0]      len2,
    input  ptsd_pkg::res_t               res_in,
    output logic                         valid_out,
    output logic [ptsd_pkg::RW-1:0]      root,
    output ptsd_pkg::res_t               res_out
);
    import ptsd_pkg::*;

    logic          v_reg   [0:RW];
    logic [XW-1:0] rem_reg [0:RW];
    logic [RW-1:0] rt_reg  [0:RW];
    res_t          res_reg [0:RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= XW'(len2);
        rt_reg[0]  <= '0;
        res_reg[0] <= res_in;
    end

    for (genvar j = 0; j < RW; j++)
    begin : g_stage
        localparam int BIT = RW - 1 - j;
        logic [XW-1:0] trial;
        logic          take;

        always_comb
        begin
            trial = (XW'(rt_reg[j]) << (BIT + 1)) | (XW'(1) << (2 * BIT));
            take  = rem_reg[j] >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j+1] <= 1'b0;
            end
            else
            begin
                v_reg[j+1] <= v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j+1] <= take ? rem_reg[j] - trial : rem_reg[j];
            rt_reg[j+1]  <= take ? (rt_reg[j] | (RW'(1) << BIT)) : rt_reg[j];
            res_reg[j+1] <= res_reg[j];
        end
    end

    assign valid_out = v_reg[RW];
    assign root      = rt_reg[RW];
    assign res_out   = res_reg[RW];

endmodule

`default_nettype wire

@@ rtl/point_to_segment_distance.sv @@
// Top level of the point-to-segment distance block.
// Depends on ptsd_pkg, ptsd_front, ptsd_div, ptsd_back, ptsd_sqrt and the macros header.
//
// One beat enters on any cycle with start high; busy is always low, so a new
// beat may follow every cycle. Each beat yields one result beat, shown for one
// cycle with done high. Its path runs through the five front stages, the
// 34-stage projection divider, the four back stages and the 35-stage square
// root pipeline. The receiver cannot stall the block.
`default_nettype none
`include "point_to_segment_distance_macros.svh"

module point_to_segment_distance (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire  [ptsd_pkg::IN_W-1:0]     seg_a_x,
    input  wire  [ptsd_pkg::IN_W-1:0]     seg_a_y,
    input  wire  [ptsd_pkg::IN_W-1:0]     seg_b_x,
    input  wire  [ptsd_pkg::IN_W-1:0]     seg_b_y,
    input  wire  [ptsd_pkg::IN_W-1:0]     query_x,
    input  wire  [ptsd_pkg::IN_W-1:0]     query_y,
    output logic                          done,
    output logic signed [ptsd_pkg::OUT_W-1:0] proj_x,
    output logic signed [ptsd_pkg::OUT_W-1:0] proj_y,
    output logic [ptsd_pkg::DIST_W-1:0]   dist_res,
    output logic                          at_endpoint
);
    import ptsd_pkg::*;

    logic          f_valid, d_valid, b_valid, s_valid;
    logic [NW-1:0] f_num_x, f_num_y;
    logic [SW-1:0] f_dd, b_len2;
    side_t         f_side, d_side;
    logic [QW-1:0] d_qx, d_qy;
    res_t          b_res, s_res;
    logic [RW-1:0] s_root;

    assign busy = 1'b0;

    ptsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (start),
        .seg_a_x   (seg_a_x),
        .seg_a_y   (seg_a_y),
        .seg_b_x   (seg_b_x),
        .seg_b_y   (seg_b_y),
        .query_x   (query_x),
        .query_y   (query_y),
        .valid_out (f_valid),
        .num_x     (f_num_x),
        .num_y     (f_num_y),
        .dd        (f_dd),
        .side      (f_side)
    );

    ptsd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (f_valid),
        .num_x     (f_num_x),
        .num_y     (f_num_y),
        .dd        (f_dd),
        .side_in   (f_side),
        .valid_out (d_valid),
        .quot_x    (d_qx),
        .quot_y    (d_qy),
        .side_out  (d_side)
    );

    ptsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (d_valid),
        .quot_x    (d_qx),
        .quot_y    (d_qy),
        .side      (d_side),
        .valid_out (b_valid),
        .len2      (b_len2),
        .res       (b_res)
    );

    ptsd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (b_valid),
        .len2      (b_len2),
        .res_in    (b_res),
        .valid_out (s_valid),
        .root      (s_root),
        .res_out   (s_res)
    );

    assign done        = s_valid;
    assign proj_x      = s_res.px;
    assign proj_y      = s_res.py;
    assign at_endpoint = s_res.at_endpoint;
    assign dist_res    = s_root[DIST_W-1:0];

    `PTSD_ASSERT_NEVER(a_never_busy, busy)
    `PTSD_ASSERT_IMPLY(a_done_has_start, done, $past(start, LATENCY))
    `PTSD_ASSERT_IMPLY(a_interior_in_div, d_valid && !d_side.interior, $past(f_valid, QW + 1))

endmodule

`default_nettype wire
